// ===== rtl/double_ended_queue_macros.svh =====
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define DEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
// Types and constants shared by the double-ended queue modules.
package deq_pkg;

   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_REAR  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_REAR   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_POP_EMPTY  = 2'd1,
      STAT_PUSH_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_FILL = 2'd1,
      ST_RESP = 2'd2
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic step;   // perform the accepted item's action
      logic fill;   // load the cached end value from the read port
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_fill;  // the pending pop leaves entries behind; refill a cached end
   } stat_type;

endpackage

// ===== rtl/deq_req_if.sv =====
// Request channel: one action and its push value per item.
interface deq_req_if import deq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [VALUE_W-1:0]  push_value;

   modport source (output valid, output action, output push_value, input ready);
   modport sink   (input valid, input action, input push_value, output ready);
endinterface

// ===== rtl/deq_rsp_if.sv =====
// Response channel: the result and queue status of one item.
interface deq_rsp_if import deq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  popped_value;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  front_value;
   logic [VALUE_W-1:0]  rear_value;
   logic                empty_flag;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output popped_value, output status, output front_value,
                   output rear_value, output empty_flag, output entry_count, input ready);
   modport sink   (input valid, input popped_value, input status, input front_value,
                   input rear_value, input empty_flag, input entry_count, output ready);
endinterface

// ===== rtl/deq_controller.sv =====
// Sequencing state machine of the double-ended queue.
`include "double_ended_queue_macros.svh"

module deq_controller import deq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = stat.need_fill ? ST_FILL : ST_RESP;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `DEQ_ASSERT_ALWAYS(a_one_side_open, clock, reset, !(req_ready && rsp_valid), "request taken while a response is pending")
   `DEQ_ASSERT_NEXT(a_fill_then_resp, clock, reset, cmd.fill, rsp_valid, "refill not followed by a response")
   `DEQ_ASSERT_NEXT(a_resp_done_idle, clock, reset, rsp_valid && rsp_ready, req_ready, "not ready after a response was taken")

endmodule

// ===== rtl/deq_datapath.sv =====
// Ring storage, pointers, count and cached end values of the double-ended queue.
`include "double_ended_queue_macros.svh"

module deq_datapath import deq_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [ACTION_W-1:0] action_raw,
   input  logic [VALUE_W-1:0]  push_value,
   output logic [VALUE_W-1:0]  popped_value,
   output logic [STATUS_W-1:0] status,
   output logic [VALUE_W-1:0]  front_value,
   output logic [VALUE_W-1:0]  rear_value,
   output logic                empty_flag,
   output logic [COUNT_W-1:0]  entry_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   logic [DATA_WIDTH-1:0] ring_store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [AW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0]         head_inc, head_dec, tail_inc, tail_dec;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in, rear_ff, rear_in;
   logic [DATA_WIDTH-1:0] popped_ff, popped_in, wr_data;
   status_type            status_ff, status_in;
   logic                  fill_front_ff, fill_front_in;
   logic                  wr_en, is_push, full, empty, refused;
   action_type            action;

   assign action   = action_type'(action_raw);
   assign is_push  = (action == ACT_PUSH_FRONT) || (action == ACT_PUSH_REAR);
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign refused  = is_push ? full : empty;

   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - AW'(1);
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + AW'(1);
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - AW'(1);

   // A pop that leaves entries behind must fetch the new end from the store.
   assign stat.need_fill = !is_push && (count_ff >= CW'(2));
   assign rd_addr        = (action == ACT_POP_FRONT) ? head_inc : tail_dec;
   assign wr_data        = DATA_WIDTH'(push_value);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      fill_front_in = fill_front_ff;
      wr_en         = 1'b0;
      wr_addr       = head_dec;
      if (cmd.step) begin
         status_in = STAT_OK;
         popped_in = '0;
         if (refused) begin
            status_in = is_push ? STAT_PUSH_FULL : STAT_POP_EMPTY;
         end else begin
            unique case (action)
               ACT_PUSH_FRONT: begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + CW'(1);
                  front_in = wr_data;
                  if (empty) begin
                     rear_in = wr_data;
                  end
               end
               ACT_PUSH_REAR: begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_inc;
                  tail_in  = tail_inc;
                  count_in = count_ff + CW'(1);
                  rear_in  = wr_data;
                  if (empty) begin
                     front_in = wr_data;
                  end
               end
               ACT_POP_FRONT: begin
                  popped_in     = front_ff;
                  head_in       = head_inc;
                  count_in      = count_ff - CW'(1);
                  fill_front_in = 1'b1;
               end
               ACT_POP_REAR: begin
                  popped_in     = rear_ff;
                  tail_in       = tail_dec;
                  count_in      = count_ff - CW'(1);
                  fill_front_in = 1'b0;
               end
            endcase
         end
      end
      if (cmd.fill) begin
         if (fill_front_ff) begin
            front_in = rd_data_ff;
         end else begin
            rear_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= LAST_IDX;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      rear_ff       <= rear_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      fill_front_ff <= fill_front_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ring_store_ff[rd_addr];
   end

   assign popped_value = VALUE_W'(popped_ff);
   assign status       = status_ff;
   assign empty_flag   = (count_ff == '0);
   assign front_value  = empty_flag ? '0 : VALUE_W'(front_ff);
   assign rear_value   = empty_flag ? '0 : VALUE_W'(rear_ff);
   assign entry_count  = COUNT_W'(count_ff);

   `DEQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "entry count above depth")
   `DEQ_ASSERT_ALWAYS(a_empty_ptrs, clock, reset, (count_ff != '0) || (tail_inc == head_ff), "rear pointer out of step with front on empty")
   `DEQ_ASSERT_NEXT(a_push_grows, clock, reset, cmd.step && is_push && !full, count_ff == $past(count_ff) + CW'(1), "accepted push did not add an entry")

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue.
//
// A bounded double-ended queue of DEPTH entries of DATA_WIDTH bits, kept in a
// ring store addressed by front and rear pointers. Each request item pushes at
// the front or rear, or pops from the front or rear; each yields exactly one
// response item with the popped value (zero unless a pop succeeded), a status
// (ok, pop on empty, push on full), the front and rear values after the action
// (zero when empty), an empty flag and the entry count. A refused action leaves
// the queue unchanged. One item is in flight at a time: req.ready is high only
// while no response is pending. For pushes and refused actions the response
// appears in the cycle after the request is taken; a pop that leaves entries
// behind first passes a refill state, in which the new front or rear, fetched
// through the store's registered read port, is loaded into its cache register.
// The next request is taken in the cycle after the response is taken. Values
// wider than DATA_WIDTH are truncated on push; results are zero-extended or
// truncated to 32 bits.
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req_chan,
   deq_rsp_if.source  rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   // Sequence each item: take it, optionally refill a cached end, respond.
   deq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the store, pointers, count and the response registers.
   deq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .action_raw   (req_chan.action),
      .push_value   (req_chan.push_value),
      .popped_value (rsp_chan.popped_value),
      .status       (rsp_chan.status),
      .front_value  (rsp_chan.front_value),
      .rear_value   (rsp_chan.rear_value),
      .empty_flag   (rsp_chan.empty_flag),
      .entry_count  (rsp_chan.entry_count)
   );

endmodule

// ===== sim/deq_checker.sv =====
// Result checker for the double-ended queue: predicts each response and compares it.
module deq_checker import deq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if        req_mon,
   deq_rsp_if        rsp_mon,
   output int        fail_count,
   output int        pending_count
);

   localparam int SLOT_W = $clog2(DEPTH);

   typedef struct packed {
      logic [VALUE_W-1:0] popped_value;
      status_type         status;
      logic [VALUE_W-1:0] front_value;
      logic [VALUE_W-1:0] rear_value;
      logic               empty_flag;
      logic [COUNT_W-1:0] entry_count;
   } deq_result_type;

   logic [VALUE_W-1:0] ring_copy [DEPTH];
   logic [SLOT_W-1:0]  front_slot;
   logic [COUNT_W-1:0] held;
   deq_result_type     awaited_results [$];
   int                 mismatches = 0;

   function automatic logic [SLOT_W-1:0] back_slot();
      back_slot = front_slot + held[SLOT_W-1:0] - 1'b1;
   endfunction

   // Apply one action to the shadow queue and return the response it must give.
   function automatic deq_result_type predict_deq_step(action_type act,
                                                       logic [VALUE_W-1:0] value);
      deq_result_type r;
      r        = '0;
      r.status = STAT_OK;
      case (act)
         ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
            if (held == DEPTH) begin
               r.status = STAT_PUSH_FULL;
            end else if (act == ACT_PUSH_FRONT) begin
               front_slot            = front_slot - 1'b1;
               ring_copy[front_slot] = value;
               held                  = held + 1'b1;
            end else begin
               held                  = held + 1'b1;
               ring_copy[back_slot()] = value;
            end
         end
         default: begin
            if (held == 0) begin
               r.status = STAT_POP_EMPTY;
            end else if (act == ACT_POP_FRONT) begin
               r.popped_value = ring_copy[front_slot];
               front_slot     = front_slot + 1'b1;
               held           = held - 1'b1;
            end else begin
               r.popped_value = ring_copy[back_slot()];
               held           = held - 1'b1;
            end
         end
      endcase
      r.entry_count = held;
      r.empty_flag  = (held == 0);
      if (held != 0) begin
         r.front_value = ring_copy[front_slot];
         r.rear_value  = ring_copy[back_slot()];
      end
      return r;
   endfunction

   function automatic void compare_field(string name, logic [VALUE_W-1:0] want,
                                         logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      deq_result_type want;
      if (reset) begin
         front_slot = '0;
         held       = '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               $error("response item with no request outstanding");
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               compare_field("popped_value", want.popped_value, rsp_mon.popped_value);
               compare_field("status", 32'(want.status), 32'(rsp_mon.status));
               compare_field("front_value", want.front_value, rsp_mon.front_value);
               compare_field("rear_value", want.rear_value, rsp_mon.rear_value);
               compare_field("empty_flag", 32'(want.empty_flag), 32'(rsp_mon.empty_flag));
               compare_field("entry_count", 32'(want.entry_count), 32'(rsp_mon.entry_count));
            end
         end
         if (req_mon.valid && req_mon.ready)
            awaited_results.push_back(predict_deq_step(action_type'(req_mon.action),
                                                       req_mon.push_value));
      end
      pending_count <= awaited_results.size();
      fail_count    <= mismatches;
   end

endmodule

// ===== sim/tb_double_ended_queue.sv =====
// Testbench top for the double-ended queue: stimulus, idling phases and verdict.
module tb_double_ended_queue;
   import deq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int PHASE_ITEMS    = 125;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Percent chance per cycle that the sender holds off or the receiver stalls.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int fail_count;
   int pending_count;

   deq_req_if req_chan ();
   deq_rsp_if rsp_chan ();

   double_ended_queue #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (VALUE_W)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deq_checker #(
      .DEPTH (DEPTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Drive all inputs to known values before the first edge.
   initial begin
      req_chan.valid      = 1'b0;
      req_chan.action     = ACT_PUSH_FRONT;
      req_chan.push_value = '0;
      rsp_chan.ready      = 1'b0;
   end

   // Receiver: stall at random with the current phase's probability; hold ready low in reset.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one item and wait for its handshake. Valid stays high on return, so a
   // back-to-back item only replaces the payload; a gap lowers valid first.
   task automatic send_item(input action_type act, input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.push_value <= value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Random values: mostly full-range, sometimes all zeros or all ones.
   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(9) == 0)
         return $urandom_range(1) ? '1 : '0;
      return $urandom();
   endfunction

   // Random traffic in tides: a filling tide favors pushes and a draining tide
   // favors pops, so the queue swings between empty and full and wraps the ring
   // both ways. A slice of fully random actions adds noise on top.
   task automatic random_run(input int n_items);
      logic       filling;
      logic       push;
      int         roll;
      action_type act;
      filling = 1'($urandom_range(1));
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(23) == 0)
            filling = ~filling;
         roll = $urandom_range(99);
         if (roll < 10) begin
            act = action_type'($urandom_range(3));
         end else begin
            push = filling ? ($urandom_range(99) < 85) : ($urandom_range(99) < 15);
            if (push) begin
               act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
            end else begin
               act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_REAR;
            end
         end
         send_item(act, pick_value());
      end
   endtask

   // Watchdog: end the run when no item moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: pops on an empty queue from both ends.
      send_item(ACT_POP_FRONT, 32'h1234_5678);
      send_item(ACT_POP_REAR, 32'hFFFF_FFFF);
      // Extreme values in and out, ending empty again.
      send_item(ACT_PUSH_FRONT, 32'h0000_0000);
      send_item(ACT_PUSH_REAR, 32'hFFFF_FFFF);
      send_item(ACT_POP_FRONT, 32'h0000_0000);
      send_item(ACT_POP_REAR, 32'hFFFF_FFFF);
      // Fill from both ends, wrapping the front pointer below slot zero.
      for (int i = 0; i < DEPTH; i++) begin
         if (i[0])
            send_item(ACT_PUSH_REAR, 32'hAAAA_0000 | i);
         else
            send_item(ACT_PUSH_FRONT, 32'h5555_0000 | i);
      end
      // Pushes on a full queue at both ends.
      send_item(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
      send_item(ACT_PUSH_REAR, 32'h0000_0000);

      // Random phases: free flow, slow sender, slow receiver, both sluggish.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 85;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 85;
            end
            default: begin
               send_idle_pct  = 22;
               recv_stall_pct = 22;
            end
         endcase
         random_run(PHASE_ITEMS);
      end

      // Drop valid and drain: advance one edge so the last expectation is counted.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
